// ===== rtl/ffva_pkg.sv =====
// shared types and codes for the first-fit volume allocator
`default_nettype none

package ffva_pkg;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LIST   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_FULL     = 3'd1;
   localparam logic [2:0] STATUS_NO_SPACE = 3'd2;
   localparam logic [2:0] STATUS_NO_VOL   = 3'd3;
   localparam logic [2:0] STATUS_BAD_SIZE = 3'd4;

   localparam logic [1:0] VOL_TYPE_OTHER = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIVIDE,
      ST_DELETE,
      ST_LIST,
      ST_REPLY
   } ffva_state_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [8:0] req_size;
      logic [1:0] req_type;
      logic [3:0] vol_number;
   } ffva_req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] entry_index;
      logic [3:0] start_cyl;
      logic [3:0] start_sec;
      logic [8:0] vol_size;
      logic [1:0] vol_type;
      logic [7:0] free_sectors;
      logic       last;
   } ffva_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/first_fit_volume_allocator_top.sv =====
// first-fit volume allocator: volume table, interval scan and command sequencer
// create: accept, a scan with one table entry compared per cycle (a hit restarts
//   the pass), then repeated subtract-by-SECTORS_PER_CYLINDER to split the start,
//   then a reply; delete: accept, a shift of the table, then a reply
// list: one result per cycle while the output is free, count+1 results
// a new request is taken only in idle; reset clears the volume count and state,
// table contents stay undefined until written
`default_nettype none

module first_fit_volume_allocator_top
   import ffva_pkg::*;
#(
   parameter int CYLINDERS            = 16,
   parameter int SECTORS_PER_CYLINDER = 16,
   parameter int MAX_VOLUMES          = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire ffva_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ffva_rsp_type      rsp_data
);

   localparam int TOTAL = CYLINDERS * SECTORS_PER_CYLINDER;
   localparam int LW    = $clog2(TOTAL + 257);
   localparam int CW    = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
   localparam int SW    = (SECTORS_PER_CYLINDER > 1) ? $clog2(SECTORS_PER_CYLINDER) : 1;
   localparam int IW    = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
   localparam int CNW   = $clog2(MAX_VOLUMES + 1);
   localparam int CMPW  = (CNW > 4) ? CNW : 4;

   ffva_state_type state_ff, state_in;
   logic [CNW-1:0] count_ff, count_in;
   logic [CNW-1:0] ptr_ff, ptr_in;
   logic [LW-1:0]  free_ff, free_in;
   logic [LW-1:0]  cand_ff, cand_in;
   logic [LW-1:0]  lim_ff, lim_in;
   logic [LW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  quo_ff, quo_in;
   logic [8:0]     cur_size_ff, cur_size_in;
   logic [1:0]     cur_type_ff, cur_type_in;
   ffva_rsp_type   pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   ffva_rsp_type   rsp_data_ff, rsp_data_in;

   logic [LW-1:0]  base_ff [MAX_VOLUMES];
   logic [LW-1:0]  base_in [MAX_VOLUMES];
   logic [LW-1:0]  end_ff  [MAX_VOLUMES];
   logic [LW-1:0]  end_in  [MAX_VOLUMES];
   logic [CW-1:0]  cyl_ff  [MAX_VOLUMES];
   logic [CW-1:0]  cyl_in  [MAX_VOLUMES];
   logic [SW-1:0]  sec_ff  [MAX_VOLUMES];
   logic [SW-1:0]  sec_in  [MAX_VOLUMES];
   logic [8:0]     size_ff [MAX_VOLUMES];
   logic [8:0]     size_in [MAX_VOLUMES];
   logic [1:0]     vtype_ff[MAX_VOLUMES];
   logic [1:0]     vtype_in[MAX_VOLUMES];

   logic [IW-1:0]  pidx;
   logic [IW-1:0]  widx;
   logic           out_free;
   logic           hit;
   logic [LW-1:0]  free_after_add;
   logic [LW-1:0]  free_after_del;

   assign pidx      = ptr_ff[IW-1:0];
   assign widx      = count_ff[IW-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the shared compare unit: does entry ptr overlap [cand, lim)
   assign hit = (base_ff[pidx] < lim_ff) && (end_ff[pidx] > cand_ff);
   assign free_after_add = free_ff - LW'(cur_size_ff);
   assign free_after_del = free_ff + LW'(size_ff[pidx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         free_ff      <= LW'(TOTAL - 1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      cand_ff     <= cand_in;
      lim_ff      <= lim_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cur_size_ff <= cur_size_in;
      cur_type_ff <= cur_type_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      base_ff     <= base_in;
      end_ff      <= end_in;
      cyl_ff      <= cyl_in;
      sec_ff      <= sec_in;
      size_ff     <= size_in;
      vtype_ff    <= vtype_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      ptr_in       = ptr_ff;
      cand_in      = cand_ff;
      lim_in       = lim_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cur_size_in  = cur_size_ff;
      cur_type_in  = cur_type_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      base_in      = base_ff;
      end_in       = end_ff;
      cyl_in       = cyl_ff;
      sec_in       = sec_ff;
      size_in      = size_ff;
      vtype_in     = vtype_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_size_in = req_data.req_size;
               cur_type_in = (req_data.req_type > VOL_TYPE_OTHER) ? VOL_TYPE_OTHER
                                                                  : req_data.req_type;
               pend_in              = '0;
               pend_in.last         = 1'b1;
               pend_in.free_sectors = 8'(free_ff);
               unique case (req_data.cmd)
                  CMD_CREATE: begin
                     if (count_ff >= CNW'(MAX_VOLUMES)) begin
                        pend_in.status = STATUS_FULL;
                        state_in       = ST_REPLY;
                     end else if (req_data.req_size == 9'd0) begin
                        pend_in.status = STATUS_BAD_SIZE;
                        state_in       = ST_REPLY;
                     end else begin
                        // first candidate is right after the boot sector
                        cand_in  = LW'(1);
                        lim_in   = LW'(1) + LW'(req_data.req_size);
                        ptr_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_DELETE: begin
                     if ((req_data.vol_number == 4'd0) ||
                         (CMPW'(req_data.vol_number) > CMPW'(count_ff))) begin
                        pend_in.status = STATUS_NO_VOL;
                        state_in       = ST_REPLY;
                     end else begin
                        ptr_in   = CNW'(req_data.vol_number - 4'd1);
                        state_in = ST_DELETE;
                     end
                  end
                  CMD_LIST: begin
                     ptr_in   = '0;
                     state_in = ST_LIST;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (lim_ff > LW'(TOTAL)) begin
               pend_in.status = STATUS_NO_SPACE;
               state_in       = ST_REPLY;
            end else if (count_ff == '0) begin
               rem_in   = cand_ff;
               quo_in   = '0;
               state_in = ST_DIVIDE;
            end else if (hit) begin
               // jump past the blocking volume and restart the pass
               cand_in = end_ff[pidx];
               lim_in  = end_ff[pidx] + LW'(cur_size_ff);
               ptr_in  = '0;
            end else if (ptr_ff == count_ff - CNW'(1)) begin
               rem_in   = cand_ff;
               quo_in   = '0;
               state_in = ST_DIVIDE;
            end else begin
               ptr_in = ptr_ff + CNW'(1);
            end
         end

         ST_DIVIDE: begin
            if (rem_ff >= LW'(SECTORS_PER_CYLINDER)) begin
               rem_in = rem_ff - LW'(SECTORS_PER_CYLINDER);
               quo_in = quo_ff + CW'(1);
            end else begin
               base_in[widx]        = cand_ff;
               end_in[widx]         = lim_ff;
               cyl_in[widx]         = quo_ff;
               sec_in[widx]         = SW'(rem_ff);
               size_in[widx]        = cur_size_ff;
               vtype_in[widx]       = cur_type_ff;
               count_in             = count_ff + CNW'(1);
               free_in              = free_after_add;
               pend_in.status       = STATUS_OK;
               pend_in.entry_index  = 4'(count_ff + CNW'(1));
               pend_in.start_cyl    = 4'(quo_ff);
               pend_in.start_sec    = 4'(rem_ff);
               pend_in.vol_size     = cur_size_ff;
               pend_in.vol_type     = cur_type_ff;
               pend_in.free_sectors = 8'(free_after_add);
               state_in             = ST_REPLY;
            end
         end

         ST_DELETE: begin
            for (int i = 0; i < MAX_VOLUMES - 1; i++) begin
               if (CNW'(i) >= ptr_ff) begin
                  base_in[i]  = base_ff[i+1];
                  end_in[i]   = end_ff[i+1];
                  cyl_in[i]   = cyl_ff[i+1];
                  sec_in[i]   = sec_ff[i+1];
                  size_in[i]  = size_ff[i+1];
                  vtype_in[i] = vtype_ff[i+1];
               end
            end
            count_in             = count_ff - CNW'(1);
            free_in              = free_after_del;
            pend_in.free_sectors = 8'(free_after_del);
            state_in             = ST_REPLY;
         end

         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in              = '0;
               rsp_data_in.free_sectors = 8'(free_ff);
               if (ptr_ff < count_ff) begin
                  rsp_data_in.entry_index = 4'(ptr_ff + CNW'(1));
                  rsp_data_in.start_cyl   = 4'(cyl_ff[pidx]);
                  rsp_data_in.start_sec   = 4'(sec_ff[pidx]);
                  rsp_data_in.vol_size    = size_ff[pidx];
                  rsp_data_in.vol_type    = vtype_ff[pidx];
                  ptr_in                  = ptr_ff + CNW'(1);
               end else begin
                  rsp_data_in.last = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the table never holds more entries than it has room for
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNW'(MAX_VOLUMES))
      else $error("volume count above table depth");

   // in scan and divide the window spans exactly the requested size
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DIVIDE) |-> lim_ff == cand_ff + LW'(cur_size_ff))
      else $error("scan window out of step with request size");

   // a known command always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.cmd != CMD_UNUSED) |=> state_ff != ST_IDLE)
      else $error("accepted command did not start");

   // only the final result of a run may carry an error status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> rsp_data.status == STATUS_OK)
      else $error("error status on a non-final result");

endmodule

`default_nettype wire
